### hw/rtl/efcs_pkg.sv
package efcs_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam int HDR_LEN = 14;
  localparam int FCS_LEN = 4;
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HDR_LEN - 1);
  localparam logic [CNT_W-1:0] FCS_LAST = CNT_W'(FCS_LEN - 1);

  typedef struct packed {
    logic        first;
    logic        has;
    logic        last;
    logic [7:0]  pbyte;
    logic [47:0] dmac;
    logic [15:0] etype;
  } cmd_t;

  typedef enum logic [1:0] {
    STEP_START,
    STEP_HDR,
    STEP_DATA,
    STEP_FCS
  } step_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/efcs_if.sv
interface efcs_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        has_byte;
  logic        last_byte;
  logic [47:0] dest_mac;
  logic [15:0] ether_type;

  modport source (output valid, payload_byte, has_byte, last_byte, dest_mac, ether_type,
                  input ready);
  modport sink (input valid, payload_byte, has_byte, last_byte, dest_mac, ether_type,
                output ready);
endinterface

interface efcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

### hw/rtl/efcs_front.sv
module efcs_front
  import efcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_has_byte,
  input  logic        in_last_byte,
  input  logic [47:0] in_dest_mac,
  input  logic [15:0] in_ether_type,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_wdata
);

  logic in_frame_r;
  logic in_frame_nxt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.first = !in_frame_r;
    q_wdata.has   = in_has_byte;
    q_wdata.last  = in_last_byte;
    q_wdata.pbyte = in_payload_byte;
    q_wdata.dmac  = in_dest_mac;
    q_wdata.etype = in_ether_type;
    in_frame_nxt  = in_frame_r;
    if (q_push) begin
      in_frame_nxt = !in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

### hw/rtl/efcs_queue.sv
module efcs_queue
  import efcs_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign rdata     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hw/rtl/efcs_back.sv
module efcs_back
  import efcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [47:0] source_mac,
  input  logic        q_valid,
  input  cmd_t        q_rdata,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_end
);

  step_t            step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             end_r, end_nxt;

  step_t        cur;
  step_t        after;
  logic         can_emit;
  logic         emit;
  logic [111:0] hdr;
  logic [31:0]  fcs;
  logic [31:0]  crc_in;
  logic [7:0]   cur_byte;

  assign out_valid      = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_frame_end  = end_r;

  always_comb begin
    cur = step_r;
    if (step_r == STEP_START) begin
      if (q_rdata.first) begin
        cur = STEP_HDR;
      end else if (q_rdata.has) begin
        cur = STEP_DATA;
      end else if (q_rdata.last) begin
        cur = STEP_FCS;
      end else begin
        cur = STEP_START;
      end
    end

    hdr      = {q_rdata.dmac, source_mac, q_rdata.etype};
    fcs      = ~crc_r;
    can_emit = !out_valid_r || out_ready;
    emit     = q_valid && (cur != STEP_START) && can_emit;
    crc_in   = (cur == STEP_HDR && cnt_r == '0) ? CRC_INIT : crc_r;

    case (cur)
      STEP_HDR:  cur_byte = hdr[(HDR_LEN - 1 - int'(cnt_r)) * 8 +: 8];
      STEP_DATA: cur_byte = q_rdata.pbyte;
      STEP_FCS:  cur_byte = fcs[int'(cnt_r[1:0]) * 8 +: 8];
      default:   cur_byte = 8'h00;
    endcase

    after = STEP_START;
    case (cur)
      STEP_HDR: begin
        if (q_rdata.has) begin
          after = STEP_DATA;
        end else if (q_rdata.last) begin
          after = STEP_FCS;
        end
      end
      STEP_DATA: begin
        if (q_rdata.last) begin
          after = STEP_FCS;
        end
      end
      default: after = STEP_START;
    endcase

    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    end_nxt       = end_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (q_valid && cur == STEP_START) begin
      q_pop    = 1'b1;
      step_nxt = STEP_START;
      cnt_nxt  = '0;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = cur_byte;
      end_nxt       = (cur == STEP_FCS) && (cnt_r == FCS_LAST);
      if (cur != STEP_FCS) begin
        crc_nxt = crc_byte(crc_in, cur_byte);
      end
      if ((cur == STEP_HDR && cnt_r != HDR_LAST) ||
          (cur == STEP_FCS && cnt_r != FCS_LAST)) begin
        step_nxt = cur;
        cnt_nxt  = cnt_r + 1'b1;
      end else begin
        cnt_nxt = '0;
        if (after == STEP_START) begin
          q_pop    = 1'b1;
          step_nxt = STEP_START;
        end else begin
          step_nxt = after;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_START;
      cnt_r       <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
  end

endmodule

### hw/rtl/ethernet_frame_tx_fcs.sv
// Ethernet frame builder with CRC-32 frame check sequence.
// in_if carries payload requests: payload_byte, has_byte, last_byte, and on
// the first request of a packet dest_mac and ether_type. out_if carries the
// frame in wire order, one byte per transfer; frame_end marks the last FCS byte.
// cfg_we/cfg_wdata load the station source MAC; write it between packets.
// The first request of a packet yields the 14-byte header (destination,
// source, type, most significant byte first), then its byte if has_byte is
// set; a request with last_byte yields the 4 FCS bytes, least significant first.
// An accepted request's first byte passes through the request queue and the
// output register before it appears on out_if when the sequencer is idle.
// Throughput: one output byte per cycle, set by the output sequencer, while
// requests are queued and out_if.ready is not held low. The input stalls
// while the QDEPTH-entry request queue is full.
// Reset clears the queue, the sequencer and the output valid flag; the source
// MAC returns to zero. When the receiver holds out_if.ready low, the output
// byte holds, the sequencer waits and the queue fills, then in_if.ready drops.
module ethernet_frame_tx_fcs
  import efcs_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  efcs_in_if.sink     in_if,
  efcs_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [47:0] cfg_wdata
);

  logic [47:0] source_mac_r;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  cmd_t        q_wdata;
  cmd_t        q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_mac_r <= '0;
    end else if (cfg_we) begin
      source_mac_r <= cfg_wdata;
    end
  end

  efcs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_payload_byte (in_if.payload_byte),
    .in_has_byte     (in_if.has_byte),
    .in_last_byte    (in_if.last_byte),
    .in_dest_mac     (in_if.dest_mac),
    .in_ether_type   (in_if.ether_type),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  efcs_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  efcs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .source_mac     (source_mac_r),
    .q_valid        (q_valid),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_frame_byte (out_if.frame_byte),
    .out_frame_end  (out_if.frame_end)
  );

endmodule

### hw/rtl/efcs_checker.sv
module efcs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_frame_byte,
  input logic       out_frame_end
);

  logic seen_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_in_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      seen_in_r <= 1'b1;
    end
  end

  a_reset_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_in_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> seen_in_r)
    else $error("output before any accepted request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte) && $stable(out_frame_end))
    else $error("stalled output changed");

endmodule

bind ethernet_frame_tx_fcs efcs_checker u_efcs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_frame_byte (out_if.frame_byte),
  .out_frame_end  (out_if.frame_end)
);

### tb/sv/tb.sv
module tb;
  import efcs_pkg::*;

  localparam int WATCHDOG = 5000;
  localparam int HOLD_AT = 250;
  localparam int HOLD_LEN = 300;
  localparam int PHASE_ITEMS = 30;

  typedef struct {
    logic [7:0]  pbyte;
    logic        has;
    logic        last;
    logic [47:0] dmac;
    logic [15:0] etype;
  } pay_req_t;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } wire_byte_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [47:0] cfg_wdata;

  efcs_in_if  in_ch ();
  efcs_out_if out_ch ();

  ethernet_frame_tx_fcs u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pay_req_t   pend_reqs[$];
  pay_req_t   cur_req;
  wire_byte_t frame_bytes_due[$];
  wire_byte_t due;

  logic [47:0] src_mac_copy;
  logic        in_pkt;
  logic [31:0] crc_run;

  logic send_idle;
  logic recv_idle;
  logic hold_done;
  int   send_gap;
  int   recv_gap;
  int   hold_left;
  int   out_cnt;
  int   err_cnt;
  int   stall_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb = crc[0] ^ b[k];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic int draw_gap(input logic enabled);
    if (!enabled || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  task automatic emit_hashed(input logic [7:0] b);
    crc_run = crc_step(crc_run, b);
    frame_bytes_due.push_back('{data: b, fin: 1'b0});
  endtask

  task automatic build_frame(input pay_req_t r);
    logic [31:0] fcs;
    if (!in_pkt) begin
      crc_run = CRC_INIT;
      for (int i = 5; i >= 0; i--) begin
        emit_hashed(r.dmac[8*i +: 8]);
      end
      for (int i = 5; i >= 0; i--) begin
        emit_hashed(src_mac_copy[8*i +: 8]);
      end
      emit_hashed(r.etype[15:8]);
      emit_hashed(r.etype[7:0]);
      in_pkt = 1'b1;
    end
    if (r.has) begin
      emit_hashed(r.pbyte);
    end
    if (r.last) begin
      fcs = ~crc_run;
      for (int i = 0; i < 4; i++) begin
        frame_bytes_due.push_back('{data: fcs[8*i +: 8], fin: (i == 3)});
      end
      in_pkt = 1'b0;
      crc_run = CRC_INIT;
    end
  endtask

  task automatic flag_err(input string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic add_req(input logic [7:0] pbyte, input logic has, input logic last,
                         input logic [47:0] dmac, input logic [15:0] etype);
    pend_reqs.push_back('{pbyte: pbyte, has: has, last: last, dmac: dmac, etype: etype});
  endtask

  function automatic logic [47:0] rand_mac();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  task automatic queue_packets(input int n_items);
    int added;
    int len;
    added = 0;
    while (added < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        add_req(8'($urandom), $urandom_range(0, 7) != 0, k == len - 1, rand_mac(),
                16'($urandom));
      end
      added += len;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (pend_reqs.size() != 0 || in_ch.valid || frame_bytes_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic load_src_mac(input logic [47:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    src_mac_copy = v;
    @(negedge clk);
  endtask

  // driver: present requests, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        build_frame(cur_req);
        send_gap = draw_gap(send_idle);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pend_reqs.size() > 0) begin
          cur_req = pend_reqs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.payload_byte <= cur_req.pbyte;
          in_ch.has_byte <= cur_req.has;
          in_ch.last_byte <= cur_req.last;
          in_ch.dest_mac <= cur_req.dmac;
          in_ch.ether_type <= cur_req.etype;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each frame byte, stall at random, hold off once for long
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_cnt++;
        if (frame_bytes_due.size() == 0) begin
          flag_err($sformatf("unexpected byte %02h end %b", out_ch.frame_byte,
                             out_ch.frame_end));
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_ch.frame_byte !== due.data || out_ch.frame_end !== due.fin) begin
            flag_err($sformatf("byte %0d: expected %02h end %b, got %02h end %b", out_cnt,
                               due.data, due.fin, out_ch.frame_byte, out_ch.frame_end));
          end
        end
        recv_gap = draw_gap(recv_idle);
        if (!hold_done && out_cnt >= HOLD_AT && pend_reqs.size() > 2) begin
          hold_left = HOLD_LEN;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.payload_byte = '0;
    in_ch.has_byte = 1'b0;
    in_ch.last_byte = 1'b0;
    in_ch.dest_mac = '0;
    in_ch.ether_type = '0;
    out_ch.ready = 1'b0;
    src_mac_copy = '0;
    in_pkt = 1'b0;
    crc_run = CRC_INIT;
    out_cnt = 0;
    err_cnt = 0;
    stall_cycles = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed requests under the reset source address
    add_req(8'h00, 1'b1, 1'b1, 48'h0, 16'h0000);
    add_req(8'h5a, 1'b0, 1'b1, 48'hffff_ffff_ffff, 16'hffff);
    add_req(8'h33, 1'b0, 1'b0, 48'h0102_0304_0506, 16'h0800);
    add_req(8'hff, 1'b1, 1'b0, 48'hffff_ffff_ffff, 16'hffff);
    add_req(8'hc3, 1'b0, 1'b0, 48'h0, 16'h0);
    add_req(8'h80, 1'b1, 1'b1, 48'h1234_5678_9abc, 16'h1234);
    add_req(8'h01, 1'b1, 1'b0, 48'haaaa_aaaa_aaaa, 16'h5555);
    add_req(8'h7f, 1'b1, 1'b0, 48'h5555_5555_5555, 16'haaaa);
    add_req(8'hfe, 1'b1, 1'b1, 48'h0, 16'hffff);
    add_req(8'h11, 1'b0, 1'b0, 48'h5555_5555_5555, 16'h86dd);
    add_req(8'h22, 1'b0, 1'b0, 48'haaaa_aaaa_aaaa, 16'h0);
    add_req(8'h44, 1'b0, 1'b1, 48'hffff_ffff_ffff, 16'hffff);
    add_req(8'haa, 1'b1, 1'b0, 48'h8000_0000_0001, 16'h8001);
    add_req(8'h55, 1'b1, 1'b0, 48'h0, 16'h0);
    add_req(8'h99, 1'b0, 1'b0, 48'h0, 16'h0);
    add_req(8'h00, 1'b1, 1'b1, 48'h0, 16'h0);
    drain();

    for (int p = 1; p <= 5; p++) begin
      case (p)
        1: load_src_mac(48'hffff_ffff_ffff);
        2: load_src_mac(48'h0);
        3: load_src_mac(48'h5555_5555_5555);
        4: load_src_mac(48'({$urandom, $urandom}));
        default: load_src_mac(48'haaaa_aaaa_aaaa);
      endcase
      send_idle = (p == 1 || p == 3 || p == 5);
      recv_idle = (p == 1 || p == 4 || p == 5);
      queue_packets(PHASE_ITEMS);
      drain();
    end

    if (err_cnt == 0 && frame_bytes_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
